/* src/hsv2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Types and constants shared by the HSV to RGB conversion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

  localparam int HUE_W  = 16;
  localparam int CH_W   = 13;
  localparam int FRAC_W = 8;
  localparam int Q20_W  = 21;
  localparam int XW     = 6;

  localparam logic [CH_W-1:0]  ONE       = 13'd4096;
  localparam logic [Q20_W-1:0] Q20_ONE   = 21'd1048576;
  localparam logic [8:0]       FRAC_ONE  = 9'd256;
  localparam logic [11:0]      THIRD_MUL = 12'd43;

  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_t;

  typedef struct packed {
    logic              black;
    sector_t           sector;
    logic [FRAC_W-1:0] frac;
    logic [CH_W-1:0]   sat;
    logic [CH_W-1:0]   val;
  } dec_t;

  typedef struct packed {
    logic       black;
    sector_t    sector;
    logic [CH_W-1:0] val;
    logic [CH_W-1:0] p;
    logic [CH_W-1:0] q;
    logic [CH_W-1:0] t;
  } comp_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage

`default_nettype wire

/* src/hsv2rgb_if.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_if
// Valid/ready channels for HSV pixels in and RGB pixels out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsv_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [hsv2rgb_pkg::HUE_W-1:0]   hue;
  logic        [hsv2rgb_pkg::CH_W-1:0]    saturation;
  logic        [hsv2rgb_pkg::CH_W-1:0]    brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface rgb_if;
  logic                             valid;
  logic                             ready;
  logic [hsv2rgb_pkg::CH_W-1:0]     red;
  logic [hsv2rgb_pkg::CH_W-1:0]     green;
  logic [hsv2rgb_pkg::CH_W-1:0]     blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

/* src/hsv_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Converts one HSV pixel to one Q12 RGB pixel per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// The converter takes one pixel in every clock cycle while the output side
// does not stall; each result passes through these stages: hue decode, the
// saturation products, the brightness products and the sector mux each hold
// one register stage. When the output side stalls, every stage holds its
// contents and the input channel is not ready until the output register can
// move again; the four stages can hold four pixels in flight.
`default_nettype none

module hsv_to_rgb_converter (
  input  wire logic clk,
  input  wire logic rst,
  hsv_if.sink       hsv,
  rgb_if.source     rgb
);

  logic               en;
  logic               dec_valid;
  logic               comp_valid;
  logic               rgb_valid;
  hsv2rgb_pkg::dec_t  dec;
  hsv2rgb_pkg::comp_t comp;
  hsv2rgb_pkg::rgb_t  rgb_out;

  assign en        = !rgb_valid || rgb.ready;
  assign hsv.ready = en;

  hsv2rgb_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (hsv.valid),
    .hue        (hsv.hue),
    .saturation (hsv.saturation),
    .brightness (hsv.brightness),
    .out_valid  (dec_valid),
    .dec        (dec)
  );

  hsv2rgb_products u_products (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dec_valid),
    .dec       (dec),
    .out_valid (comp_valid),
    .comp      (comp)
  );

  hsv2rgb_mux u_mux (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (comp_valid),
    .comp      (comp),
    .out_valid (rgb_valid),
    .rgb       (rgb_out)
  );

  assign rgb.valid = rgb_valid;
  assign rgb.red   = rgb_out.red;
  assign rgb.green = rgb_out.green;
  assign rgb.blue  = rgb_out.blue;

endmodule

`default_nettype wire

/* src/hsv2rgb_decode.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_decode
// First stage: reduces the hue modulo one turn into sector and fraction,
// blacks negative hues off whole turns; clamps saturation, brightness to one.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_decode (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 en,
  input  wire logic                                 in_valid,
  input  wire logic signed [hsv2rgb_pkg::HUE_W-1:0] hue,
  input  wire logic [hsv2rgb_pkg::CH_W-1:0]         saturation,
  input  wire logic [hsv2rgb_pkg::CH_W-1:0]         brightness,
  output logic                                      out_valid,
  output hsv2rgb_pkg::dec_t                         dec
);

  logic [hsv2rgb_pkg::XW-1:0] turn_x;
  logic [11:0]                x43;
  logic [4:0]                 third;
  logic [6:0]                 three_third;
  logic [6:0]                 mod_full;
  logic [1:0]                 mod3;
  logic                       neg;
  hsv2rgb_pkg::dec_t          dec_next;

  // One turn is 3 * 512, so the hue splits into 512-unit blocks reduced mod 3.
  assign turn_x      = hue[14:9];
  assign x43         = {6'b0, turn_x} * hsv2rgb_pkg::THIRD_MUL;
  assign third       = x43[11:7];
  assign three_third = {1'b0, third, 1'b0} + {2'b0, third};
  assign mod_full    = {1'b0, turn_x} - three_third;
  assign mod3        = mod_full[1:0];
  assign neg         = hue[15];

  always_comb begin
    dec_next.sat = (saturation > hsv2rgb_pkg::ONE) ? hsv2rgb_pkg::ONE : saturation;
    dec_next.val = (brightness > hsv2rgb_pkg::ONE) ? hsv2rgb_pkg::ONE : brightness;
    if (neg) begin
      // A negative hue is black unless it is an exact multiple of one turn.
      dec_next.black  = !((hue[8:0] == 9'd0) && (mod3 == 2'd1));
      dec_next.sector = hsv2rgb_pkg::SEC_R_TO_Y;
      dec_next.frac   = '0;
    end else begin
      dec_next.black  = 1'b0;
      dec_next.sector = hsv2rgb_pkg::sector_t'({mod3, hue[8]});
      dec_next.frac   = hue[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec <= dec_next;
    end
  end

endmodule

`default_nettype wire

/* src/hsv2rgb_products.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_products
// Two stages: saturation times fraction, then brightness times the
// complements, giving the P, Q and T channel levels.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_products (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire hsv2rgb_pkg::dec_t dec,
  output logic                   out_valid,
  output hsv2rgb_pkg::comp_t     comp
);

  logic [hsv2rgb_pkg::Q20_W-1:0] sf_next;
  logic [hsv2rgb_pkg::Q20_W-1:0] st_next;
  logic [hsv2rgb_pkg::CH_W-1:0]  pd_next;

  logic                          mid_valid;
  logic [hsv2rgb_pkg::Q20_W-1:0] sf;
  logic [hsv2rgb_pkg::Q20_W-1:0] st;
  logic [hsv2rgb_pkg::CH_W-1:0]  pd;
  logic [hsv2rgb_pkg::CH_W-1:0]  mid_val;
  logic                          mid_black;
  hsv2rgb_pkg::sector_t          mid_sector;

  logic [hsv2rgb_pkg::Q20_W-1:0] qa;
  logic [hsv2rgb_pkg::Q20_W-1:0] ta;
  logic [33:0]                   q_prod;
  logic [33:0]                   t_prod;
  logic [25:0]                   p_prod;
  hsv2rgb_pkg::comp_t            comp_next;

  assign sf_next = {8'b0, dec.sat} * {13'b0, dec.frac};
  assign st_next = {8'b0, dec.sat} * {12'b0, hsv2rgb_pkg::FRAC_ONE - {1'b0, dec.frac}};
  assign pd_next = hsv2rgb_pkg::ONE - dec.sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sf         <= sf_next;
      st         <= st_next;
      pd         <= pd_next;
      mid_val    <= dec.val;
      mid_black  <= dec.black;
      mid_sector <= dec.sector;
    end
  end

  assign qa     = hsv2rgb_pkg::Q20_ONE - sf;
  assign ta     = hsv2rgb_pkg::Q20_ONE - st;
  assign q_prod = {21'b0, mid_val} * {13'b0, qa};
  assign t_prod = {21'b0, mid_val} * {13'b0, ta};
  assign p_prod = {13'b0, mid_val} * {13'b0, pd};

  always_comb begin
    comp_next.black  = mid_black;
    comp_next.sector = mid_sector;
    comp_next.val    = mid_val;
    comp_next.p      = p_prod[24:12];
    comp_next.q      = q_prod[32:20];
    comp_next.t      = t_prod[32:20];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      comp <= comp_next;
    end
  end

endmodule

`default_nettype wire

/* src/hsv2rgb_mux.sv */
// ----------------------------------------------------------------------------
// hsv2rgb_mux
// Last stage: routes V, P, Q and T to red, green and blue by sector, or
// zeroes them for a black pixel, and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_mux (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire hsv2rgb_pkg::comp_t comp,
  output logic                    out_valid,
  output hsv2rgb_pkg::rgb_t       rgb
);

  hsv2rgb_pkg::rgb_t rgb_next;

  always_comb begin
    case (comp.sector)
      hsv2rgb_pkg::SEC_R_TO_Y: rgb_next = '{comp.val, comp.t, comp.p};
      hsv2rgb_pkg::SEC_Y_TO_G: rgb_next = '{comp.q, comp.val, comp.p};
      hsv2rgb_pkg::SEC_G_TO_C: rgb_next = '{comp.p, comp.val, comp.t};
      hsv2rgb_pkg::SEC_C_TO_B: rgb_next = '{comp.p, comp.q, comp.val};
      hsv2rgb_pkg::SEC_B_TO_M: rgb_next = '{comp.t, comp.p, comp.val};
      default:                 rgb_next = '{comp.val, comp.p, comp.q};
    endcase
    if (comp.black) begin
      rgb_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rgb <= rgb_next;
    end
  end

endmodule

`default_nettype wire

/* test/hsv_to_rgb_converter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_tb
// Self-checking bench for the HSV to RGB converter. A short table of
// directed pixels covers the hue, saturation and brightness extremes, every
// sector, negative hues and out-of-range inputs. It is followed by random
// pixels. Both channels idle and stall at random, and every result is
// compared in order against a known value or the behavioral model.
// ----------------------------------------------------------------------------

module hsv_to_rgb_converter_tb;

  localparam int HUE_TURN     = 1536;
  localparam int RANDOM_PIXELS = 530;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic signed [hsv2rgb_pkg::HUE_W-1:0] hue;
    logic [hsv2rgb_pkg::CH_W-1:0]         sat;
    logic [hsv2rgb_pkg::CH_W-1:0]         bri;
    logic                                 known;
    hsv2rgb_pkg::rgb_t                    known_rgb;
  } pixel_row_t;

  localparam hsv2rgb_pkg::rgb_t BLACK = '{red: 13'd0, green: 13'd0, blue: 13'd0};
  localparam hsv2rgb_pkg::rgb_t WHITE = '{red: 13'd4096, green: 13'd4096, blue: 13'd4096};
  localparam hsv2rgb_pkg::rgb_t RED   = '{red: 13'd4096, green: 13'd0, blue: 13'd0};

  localparam int NUM_ROWS = 22;
  localparam pixel_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{16'sd0,      13'd0,    13'd0,    1'b1, BLACK},
    '{16'sd0,      13'd4096, 13'd4096, 1'b1, RED},
    '{16'sd0,      13'd0,    13'd4096, 1'b1, WHITE},
    '{16'sd0,      13'd0,    13'd8191, 1'b1, WHITE},
    '{16'sd1536,   13'd4096, 13'd4096, 1'b1, RED},
    '{-16'sd1536,  13'd4096, 13'd4096, 1'b1, RED},
    '{-16'sd1,     13'd4096, 13'd4096, 1'b1, BLACK},
    '{-16'sd1537,  13'd4096, 13'd4096, 1'b1, BLACK},
    '{-16'sd32768, 13'd4096, 13'd4096, 1'b1, BLACK},
    '{16'sd255,    13'd4096, 13'd4096, 1'b0, BLACK},
    '{16'sd256,    13'd4096, 13'd4096, 1'b0, BLACK},
    '{16'sd512,    13'd4096, 13'd4096, 1'b0, BLACK},
    '{16'sd768,    13'd4096, 13'd4096, 1'b0, BLACK},
    '{16'sd1024,   13'd4096, 13'd4096, 1'b0, BLACK},
    '{16'sd1280,   13'd4096, 13'd4096, 1'b0, BLACK},
    '{16'sd128,    13'd2048, 13'd3000, 1'b0, BLACK},
    '{16'sd640,    13'd2048, 13'd3000, 1'b0, BLACK},
    '{16'sd1535,   13'd4097, 13'd4097, 1'b0, BLACK},
    '{16'sd32767,  13'd8191, 13'd8191, 1'b0, BLACK},
    '{16'sd100,    13'd8191, 13'd2000, 1'b0, BLACK},
    '{16'sd700,    13'd1234, 13'd8191, 1'b0, BLACK},
    '{-16'sd3072,  13'd1000, 13'd1000, 1'b0, BLACK}
  };

  logic clk;
  logic rst;

  hsv_if hsv_ch ();
  rgb_if rgb_ch ();

  hsv_to_rgb_converter DUT (
    .clk (clk),
    .rst (rst),
    .hsv (hsv_ch),
    .rgb (rgb_ch)
  );

  hsv2rgb_pkg::rgb_t pending_rgb_q[$];
  int                pixels_sent;
  int                pixels_checked;
  int                black_pixels;
  int                mismatches;

  function automatic logic [63:0] clamp_unit(logic [hsv2rgb_pkg::CH_W-1:0] x);
    return (x > hsv2rgb_pkg::ONE) ? 64'(hsv2rgb_pkg::ONE) : 64'(x);
  endfunction

  function automatic hsv2rgb_pkg::rgb_t convert_pixel(
      logic signed [hsv2rgb_pkg::HUE_W-1:0] hue,
      logic [hsv2rgb_pkg::CH_W-1:0]         sat,
      logic [hsv2rgb_pkg::CH_W-1:0]         bri);
    int                   rem;
    logic [63:0]          s, v, f, p, q, t;
    hsv2rgb_pkg::sector_t sec;
    hsv2rgb_pkg::rgb_t    px;
    rem = int'(hue) % HUE_TURN;
    s   = clamp_unit(sat);
    v   = clamp_unit(bri);
    px  = BLACK;
    if (rem >= 0) begin
      f   = 64'(rem[hsv2rgb_pkg::FRAC_W-1:0]);
      sec = hsv2rgb_pkg::sector_t'(rem[10:8]);
      p   = (v * (64'(hsv2rgb_pkg::ONE) - s)) >> 12;
      q   = (v * (64'(hsv2rgb_pkg::Q20_ONE) - s * f)) >> 20;
      t   = (v * (64'(hsv2rgb_pkg::Q20_ONE) - s * (64'(hsv2rgb_pkg::FRAC_ONE) - f))) >> 20;
      case (sec)
        hsv2rgb_pkg::SEC_R_TO_Y: px = '{v[12:0], t[12:0], p[12:0]};
        hsv2rgb_pkg::SEC_Y_TO_G: px = '{q[12:0], v[12:0], p[12:0]};
        hsv2rgb_pkg::SEC_G_TO_C: px = '{p[12:0], v[12:0], t[12:0]};
        hsv2rgb_pkg::SEC_C_TO_B: px = '{p[12:0], q[12:0], v[12:0]};
        hsv2rgb_pkg::SEC_B_TO_M: px = '{t[12:0], p[12:0], v[12:0]};
        default:                 px = '{v[12:0], p[12:0], q[12:0]};
      endcase
    end
    return px;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [hsv2rgb_pkg::HUE_W-1:0] random_hue();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, HUE_TURN - 1));
      6:                return 16'($urandom_range(HUE_TURN, 32767));
      7:                return 16'($urandom);
      8:                return -16'($urandom_range(0, 21) * HUE_TURN);
      default:          return 16'($urandom_range(0, 6) * 256 + $urandom_range(0, 2) - 1);
    endcase
  endfunction

  function automatic logic [hsv2rgb_pkg::CH_W-1:0] random_level();
    case ($urandom_range(0, 9))
      7:       return $urandom_range(0, 1) ? hsv2rgb_pkg::ONE : '0;
      8:       return 13'($urandom_range(4097, 8191));
      9:       return 13'($urandom);
      default: return 13'($urandom_range(0, 4096));
    endcase
  endfunction

  task automatic send_pixel(input logic signed [hsv2rgb_pkg::HUE_W-1:0] hue,
                            input logic [hsv2rgb_pkg::CH_W-1:0] sat,
                            input logic [hsv2rgb_pkg::CH_W-1:0] bri,
                            input logic known,
                            input hsv2rgb_pkg::rgb_t known_rgb, input int gap);
    hsv2rgb_pkg::rgb_t want;
    if (gap > 0) begin
      hsv_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hsv_ch.valid      <= 1'b1;
    hsv_ch.hue        <= hue;
    hsv_ch.saturation <= sat;
    hsv_ch.brightness <= bri;
    @(posedge clk);
    while (!hsv_ch.ready) @(posedge clk);
    want = known ? known_rgb : convert_pixel(hue, sat, bri);
    if (want == BLACK) black_pixels++;
    pending_rgb_q.push_back(want);
    pixels_sent++;
  endtask

  task automatic wait_for_drain();
    while (pending_rgb_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d results outstanding.", pending_rgb_q.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rgb_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      rgb_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      rgb_ch.ready <= 1'b0;
      repeat (pick_gap() + 1) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    hsv2rgb_pkg::rgb_t got;
    hsv2rgb_pkg::rgb_t want;
    if (!rst && rgb_ch.valid && rgb_ch.ready) begin
      got = '{rgb_ch.red, rgb_ch.green, rgb_ch.blue};
      if (pending_rgb_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result r=%0d g=%0d b=%0d", $realtime,
                   got.red, got.green, got.blue);
      end else begin
        want = pending_rgb_q.pop_front();
        pixels_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result %0d expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     $realtime, pixels_checked, want.red, want.green, want.blue,
                     got.red, got.green, got.blue);
        end
      end
    end
  end

  initial begin
    int gap;
    pixels_sent       = 0;
    pixels_checked    = 0;
    black_pixels      = 0;
    mismatches        = 0;
    rst               <= 1'b1;
    hsv_ch.valid      <= 1'b0;
    hsv_ch.hue        <= '0;
    hsv_ch.saturation <= '0;
    hsv_ch.brightness <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i])
      send_pixel(DIRECTED_ROWS[i].hue, DIRECTED_ROWS[i].sat, DIRECTED_ROWS[i].bri,
                 DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].known_rgb, pick_gap());

    hsv_ch.valid <= 1'b0;
    wait_for_drain();

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i == RANDOM_PIXELS / 2) begin
        hsv_ch.valid <= 1'b0;
        wait_for_drain();
        @(posedge clk);
      end
      gap = ((i % 100) < 25) ? 0 : pick_gap();
      send_pixel(random_hue(), random_level(), random_level(), 1'b0, BLACK, gap);
    end
    hsv_ch.valid <= 1'b0;

    wait_for_drain();
    repeat (20) @(posedge clk);
    mismatches += pending_rgb_q.size();

    $display("Converted %0d pixels (%0d directed, %0d random), %0d of them black.",
             pixels_sent, NUM_ROWS, RANDOM_PIXELS, black_pixels);
    $display("Checked %0d results with %0d mismatches.", pixels_checked, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
